// File: sv/imptt_pkg.sv
// ----------------------------------------------------------------------------
// imptt_pkg
// Shared types and constants of the indexed max-priority task table.
// ----------------------------------------------------------------------------
`default_nettype none

package imptt_pkg;

	localparam int TASK_SLOTS_DEF    = 256;
	localparam int PRIORITY_BITS_DEF = 16;
	localparam int USER_BITS_DEF     = 16;

	localparam int IN_W  = 48;
	localparam int OUT_W = 24;
	localparam int OWN_W = 16;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_EDIT   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_EXEC   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_OREAD,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [5:0]  pad;
		logic [15:0] priority_req;
		logic [15:0] user_id;
		logic [7:0]  task_id;
		cmd_t        command;
	} in_word_t;

	typedef struct packed {
		status_t          status;
		logic             found;
		logic [OWN_W-1:0] owner;
	} result_t;

endpackage

`default_nettype wire

// File: sv/indexed_max_priority_task_table_core.sv
// ----------------------------------------------------------------------------
// indexed_max_priority_task_table_core
// Task table indexed by task id with add, edit, remove and execute-top.
// One word in gives one word out. Add, edit and remove go to the finish state,
// which loads the result into the output register once that register is free.
// Execute top sweeps the priority memory one slot per cycle through its single
// read port, then reads the owner memory. Items are handled one at a time; the
// output register lets the next word in while a result waits.
// Live marks are flip-flops cleared at reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_max_priority_task_table_core #(
	parameter int TASK_SLOTS    = imptt_pkg::TASK_SLOTS_DEF,
	parameter int PRIORITY_BITS = imptt_pkg::PRIORITY_BITS_DEF,
	parameter int USER_BITS     = imptt_pkg::USER_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// command[1:0], task_id[9:2], user_id[25:10], priority_req[41:26], zero pad
	input  logic [imptt_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// owner[15:0], found[16], status[18:17], zero pad
	output logic [imptt_pkg::OUT_W-1:0] m_axis_tdata
);

	import imptt_pkg::*;

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

	state_t state_q, state_d;
	in_word_t in_w;
	logic accept;
	logic [31:0] id_ext;
	logic in_range;
	logic [SLOT_W-1:0] id_idx;
	logic id_live;
	logic [PRIORITY_BITS-1:0] prio_in;
	logic [USER_BITS-1:0] user_in;

	logic [TASK_SLOTS-1:0] live_q;
	logic [PRIORITY_BITS-1:0] prio_mem [TASK_SLOTS];
	logic [USER_BITS-1:0] owner_mem [TASK_SLOTS];

	cmd_t cmd_q;
	status_t st_q;
	logic [SLOT_W-1:0] scan_q;
	logic scan_v_s1;
	logic live_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [PRIORITY_BITS-1:0] prio_rd_q;
	logic [USER_BITS-1:0] owner_rd_q;
	logic any_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic [SLOT_W-1:0] best_slot_q;

	logic out_load;
	logic m_valid_q;
	result_t res;
	result_t m_data_q;

	assign in_w     = in_word_t'(s_axis_tdata);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign id_ext   = 32'(in_w.task_id);
	assign in_range = id_ext < 32'(TASK_SLOTS);
	assign id_idx   = id_ext[SLOT_W-1:0];
	assign id_live  = live_q[id_idx];
	assign prio_in  = PRIORITY_BITS'(32'(in_w.priority_req));
	assign user_in  = USER_BITS'(32'(in_w.user_id));

	always_ff @(posedge clk) begin
		if (accept && in_range &&
		    (in_w.command == CMD_ADD || (in_w.command == CMD_EDIT && id_live))) begin
			prio_mem[id_idx] <= prio_in;
		end
		if (accept && in_range && in_w.command == CMD_ADD) begin
			owner_mem[id_idx] <= user_in;
		end
		prio_rd_q  <= prio_mem[scan_q];
		owner_rd_q <= owner_mem[best_slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (accept && in_range && in_w.command == CMD_ADD) begin
			live_q[id_idx] <= 1'b1;
		end else if (accept && in_range && in_w.command == CMD_REMOVE) begin
			live_q[id_idx] <= 1'b0;
		end else if (state_q == S_OREAD && any_q) begin
			live_q[best_slot_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_w.command;
			if (!in_range) begin
				st_q <= ST_ABSENT;
			end else if (in_w.command == CMD_ADD) begin
				st_q <= ST_OK;
			end else if (!id_live) begin
				st_q <= ST_ABSENT;
			end else begin
				st_q <= ST_OK;
			end
		end
		slot_s1 <= scan_q;
		live_s1 <= live_q[scan_q];
		if (scan_v_s1 && live_s1 && (!any_q || prio_rd_q >= best_prio_q)) begin
			best_prio_q <= prio_rd_q;
			best_slot_q <= slot_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			scan_q    <= '0;
			scan_v_s1 <= 1'b0;
			any_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= (state_q == S_SCAN);
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == S_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
			if (accept) begin
				any_q <= 1'b0;
			end else if (scan_v_s1 && live_s1) begin
				any_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = (in_w.command == CMD_EXEC) ? S_SCAN : S_FIN;
				end
			end
			S_SCAN: begin
				if (scan_q == LAST_SLOT) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_OREAD;
			end
			S_OREAD: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		res = '0;
		if (cmd_q == CMD_EXEC) begin
			if (any_q) begin
				res.status = ST_OK;
				res.found  = 1'b1;
				res.owner  = OWN_W'(32'(owner_rd_q));
			end else begin
				res.status = ST_EMPTY;
			end
		end else begin
			res.status = st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, m_data_q};

endmodule

`default_nettype wire

// File: sv/imptt_check.sv
// ----------------------------------------------------------------------------
// imptt_check
// Port-level checks of the task table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module imptt_check (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_axis_tvalid,
	input wire logic                       s_axis_tready,
	input wire logic [imptt_pkg::IN_W-1:0]  s_axis_tdata,
	input wire logic                       m_axis_tvalid,
	input wire logic                       m_axis_tready,
	input wire logic [imptt_pkg::OUT_W-1:0] m_axis_tdata
);

	import imptt_pkg::*;

	in_word_t in_w;
	result_t  out_w;

	assign in_w  = in_word_t'(s_axis_tdata);
	assign out_w = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_w.found |-> out_w.status == ST_OK)
		else $error("found word without ok status");

	a_owner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !out_w.found |-> out_w.owner == '0)
		else $error("owner set on word without a found task");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word taken while one is in work");

	a_add_ok: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && in_w.command == CMD_ADD && !m_axis_tvalid
		|=> ##1 m_axis_tvalid && out_w.status != ST_EMPTY && !out_w.found)
		else $error("add did not report in two cycles");

endmodule

bind indexed_max_priority_task_table_core imptt_check u_imptt_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed max-priority task table. A directed
// table covers empty, absent, tie-break and overwrite cases; then 1600 random
// commands, edits and removes mostly on live tasks, run against an in-bench
// model with random input gaps and output stalls, bar the last 200 commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import imptt_pkg::*;

	localparam int SLOTS      = TASK_SLOTS_DEF;
	localparam int RAND_ITEMS = 1600;
	localparam int CALM_ITEMS = 200;
	localparam int TAIL_WAIT  = 400;
	localparam int CYCLE_CAP  = 2000000;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  id;
		logic [15:0] user;
		logic [15:0] prio;
		logic        typed;
		result_t     res;
	} plan_row_t;

	localparam plan_row_t PLAN [0:23] = '{
		'{CMD_EXEC,   8'd0,   16'h0000, 16'h0000, 1'b1, '{ST_EMPTY,  1'b0, 16'h0000}},
		'{CMD_EDIT,   8'd0,   16'h0000, 16'hffff, 1'b1, '{ST_ABSENT, 1'b0, 16'h0000}},
		'{CMD_REMOVE, 8'd255, 16'hffff, 16'h0000, 1'b1, '{ST_ABSENT, 1'b0, 16'h0000}},
		'{CMD_ADD,    8'd0,   16'hffff, 16'h0000, 1'b1, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_ADD,    8'd255, 16'h0000, 16'hffff, 1'b1, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_ADD,    8'd128, 16'h1234, 16'hffff, 1'b1, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_EXEC,   8'd0,   16'h0000, 16'h0000, 1'b1, '{ST_OK,     1'b1, 16'h0000}},
		'{CMD_EXEC,   8'd0,   16'h0000, 16'h0000, 1'b1, '{ST_OK,     1'b1, 16'h1234}},
		'{CMD_ADD,    8'd0,   16'haaaa, 16'h0005, 1'b1, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_EDIT,   8'd0,   16'h0000, 16'hffff, 1'b1, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_ADD,    8'd7,   16'h5555, 16'hffff, 1'b1, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_EXEC,   8'd0,   16'h0000, 16'h0000, 1'b1, '{ST_OK,     1'b1, 16'h5555}},
		'{CMD_REMOVE, 8'd0,   16'h0000, 16'h0000, 1'b1, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_REMOVE, 8'd0,   16'h0000, 16'h0000, 1'b1, '{ST_ABSENT, 1'b0, 16'h0000}},
		'{CMD_EXEC,   8'd0,   16'h0000, 16'h0000, 1'b1, '{ST_EMPTY,  1'b0, 16'h0000}},
		'{CMD_EDIT,   8'd7,   16'h0000, 16'h0001, 1'b1, '{ST_ABSENT, 1'b0, 16'h0000}},
		'{CMD_ADD,    8'd1,   16'hffff, 16'h8000, 1'b0, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_ADD,    8'd2,   16'h7fff, 16'h7fff, 1'b0, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_EDIT,   8'd2,   16'h0000, 16'h8001, 1'b0, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_EXEC,   8'd0,   16'h0000, 16'h0000, 1'b0, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_EXEC,   8'd0,   16'h0000, 16'h0000, 1'b0, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_EXEC,   8'd0,   16'h0000, 16'h0000, 1'b0, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_ADD,    8'd200, 16'h0000, 16'h0000, 1'b1, '{ST_OK,     1'b0, 16'h0000}},
		'{CMD_EXEC,   8'd0,   16'h0000, 16'h0000, 1'b1, '{ST_OK,     1'b1, 16'h0000}}
	};

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	// command[1:0], task_id[9:2], user_id[25:10], priority_req[41:26], zero pad
	logic [IN_W-1:0]    s_axis_tdata;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	// owner[15:0], found[16], status[18:17], zero pad
	logic [OUT_W-1:0]   m_axis_tdata;

	logic               slot_live  [SLOTS];
	logic [15:0]        slot_prio  [SLOTS];
	logic [15:0]        slot_owner [SLOTS];
	result_t            pending_results [$];

	int                 mismatch_count = 0;
	int                 cycle_count    = 0;
	int                 stall_left     = 0;
	int                 stall_pct      = 10;
	int                 gap_pct        = 20;
	bit                 calm_tail      = 1'b0;

	indexed_max_priority_task_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic result_t apply_task_cmd(cmd_t cmd, logic [7:0] id,
			logic [15:0] user, logic [15:0] prio);
		result_t     r;
		bit          any;
		logic [15:0] best_prio;
		int          best_slot;
		r = '{ST_OK, 1'b0, 16'h0000};
		any = 1'b0;
		best_prio = '0;
		best_slot = 0;
		case (cmd)
			CMD_EXEC: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_live[s] && (!any || slot_prio[s] >= best_prio)) begin
						any = 1'b1;
						best_prio = slot_prio[s];
						best_slot = s;
					end
				end
				if (any) begin
					slot_live[best_slot] = 1'b0;
					r = '{ST_OK, 1'b1, slot_owner[best_slot]};
				end else begin
					r.status = ST_EMPTY;
				end
			end
			CMD_ADD: begin
				slot_live[id] = 1'b1;
				slot_prio[id] = prio;
				slot_owner[id] = user;
			end
			default: begin
				if (!slot_live[id]) begin
					r.status = ST_ABSENT;
				end else if (cmd == CMD_EDIT) begin
					slot_prio[id] = prio;
				end else begin
					slot_live[id] = 1'b0;
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] pick_live_id();
		int start;
		start = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < SLOTS; k++) begin
			if (slot_live[(start + k) % SLOTS]) begin
				return 8'((start + k) % SLOTS);
			end
		end
		return 8'(start);
	endfunction

	task automatic hold_off(int n);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_cmd(cmd_t cmd, logic [7:0] id, logic [15:0] user,
			logic [15:0] prio, logic typed, result_t typed_res);
		in_word_t w;
		result_t  r;
		w = '0;
		w.command = cmd;
		w.task_id = id;
		w.user_id = user;
		w.priority_req = prio;
		if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
			hold_off($urandom_range(1, 13));
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do @(posedge clk); while (!s_axis_tready);
		r = apply_task_cmd(cmd, id, user, prio);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	always @(negedge clk) begin
		if (cycle_count % 256 == 0) begin
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
		end
		if (calm_tail) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(1, 13) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
			if (pending_results.size() == 0) begin
				$error("unexpected word: owner %h found %b status %0d",
					got.owner, got.found, got.status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.owner !== want.owner) begin
					$error("owner: expected %h, got %h", want.owner, got.owner);
					mismatch_count++;
				end
				if (got.found !== want.found) begin
					$error("found: expected %b, got %b", want.found, got.found);
					mismatch_count++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int          k;
		int          add_w;
		cmd_t        cmd;
		logic [7:0]  id;
		logic [15:0] prio;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		add_w = 40;
		for (int s = 0; s < SLOTS; s++) begin
			slot_live[s] = 1'b0;
			slot_prio[s] = '0;
			slot_owner[s] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[i]) begin
			send_cmd(PLAN[i].cmd, PLAN[i].id, PLAN[i].user, PLAN[i].prio,
				PLAN[i].typed, PLAN[i].res);
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 32 == 0) begin
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
			end
			if (n % 64 == 0) begin
				add_w = 25 + 15 * $urandom_range(0, 2);
			end
			calm_tail = (n >= RAND_ITEMS - CALM_ITEMS);
			k = $urandom_range(0, 99);
			if (k < add_w) begin
				cmd = CMD_ADD;
			end else if (k < add_w + 15) begin
				cmd = CMD_EDIT;
			end else if (k < add_w + 30) begin
				cmd = CMD_REMOVE;
			end else begin
				cmd = CMD_EXEC;
			end
			if ((cmd == CMD_EDIT || cmd == CMD_REMOVE) && $urandom_range(0, 9) < 8) begin
				id = pick_live_id();
			end else begin
				id = 8'($urandom_range(0, SLOTS - 1));
			end
			prio = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
			send_cmd(cmd, id, 16'($urandom), prio, 1'b0, '0);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
